@@ design/ucsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucsm_pkg
// Shared types and constants for the URL category substring matcher.
// ----------------------------------------------------------------------------
package ucsm_pkg;

  localparam int BYTE_W = 8;
  localparam int CAT_W  = 8;
  localparam int FUNC_W = 2;
  localparam int GRP_W  = 3;
  localparam int SLOT_W = 3;
  localparam int POS_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_URL   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [BYTE_W-1:0] TEXT_END = 8'd0;

  // Control group from the top level to every cell; wr is decoded per cell.
  typedef struct packed {
    logic wr;     // write one byte of this cell's pattern
    logic feed;   // advance the match vector by one text byte
    logic flush;  // drop matching state after a result
    logic clr;    // wipe pattern and matching state
  } cell_ctrl_t;

endpackage

@@ design/ucsm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucsm_cell
// One pattern cell: holds a pattern, its shift-and vector and found flag, and
// passes the slot prefix "all patterns so far are non-empty" to its neighbour.
// ----------------------------------------------------------------------------
module ucsm_cell #(
  parameter int PATTERN_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ucsm_pkg::cell_ctrl_t          ctrl,
  input  logic [ucsm_pkg::POS_W-1:0]    wr_pos,
  input  logic [ucsm_pkg::BYTE_W-1:0]   wr_byte,
  input  logic [ucsm_pkg::BYTE_W-1:0]   text_byte,
  input  logic                          nz_in,
  output logic                          nz_out,
  output logic                          hit
);
  import ucsm_pkg::*;

  logic [BYTE_W-1:0]        pat_r [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] vec_r, vec_nxt;
  logic                     found_r, found_nxt;
  logic [PATTERN_BYTES-1:0] nz, pre, eq, tail;
  logic                     end_hit, found_now;

  // Byte comparisons, length prefix and pattern-end positions.
  always_comb begin
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      nz[k] = (pat_r[k] != TEXT_END);
    end
    pre[0] = nz[0];
    for (int k = 1; k < PATTERN_BYTES; k++) begin
      pre[k] = pre[k-1] & nz[k];
    end
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      eq[k] = pre[k] & (pat_r[k] == text_byte);
    end
    for (int k = 0; k < PATTERN_BYTES - 1; k++) begin
      tail[k] = pre[k] & ~nz[k+1];
    end
    tail[PATTERN_BYTES-1] = pre[PATTERN_BYTES-1];
    vec_nxt   = {vec_r[PATTERN_BYTES-2:0], 1'b1} & eq;
    end_hit   = |(vec_nxt & tail);
    found_now = found_r | (ctrl.feed & end_hit);
    found_nxt = found_now;
  end

  assign nz_out = nz_in & nz[0];
  assign hit    = found_now & nz_out;

  // Pattern bytes.
  always_ff @(posedge clk) begin
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      if (!rst_n || ctrl.clr) begin
        pat_r[k] <= '0;
      end else if (ctrl.wr && int'(wr_pos) == k) begin
        pat_r[k] <= wr_byte;
      end
    end
  end

  // Matching state.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr || ctrl.flush) begin
      vec_r   <= '0;
      found_r <= 1'b0;
    end else if (ctrl.feed) begin
      vec_r   <= vec_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

@@ design/url_category_substring_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_category_substring_match
// Classifies a URL by matching it against a table of pattern groups.
// ----------------------------------------------------------------------------
// Usage: each transaction on the in_ channel either writes one pattern byte
// (and its group's category), streams one URL byte, or clears the table.
// A row of pattern cells updates every pattern's match vector in parallel,
// so one transaction is taken per cycle while in_ready is high.
// A URL byte with in_last_byte high produces one out_ transaction carrying
// the category of the first matching group ahead of any zero category, or 0.
// The cell row and group reduction are registered into a result stage, and
// the group priority pick into the output register.
// Other transactions produce no result.
// When the receiver stalls, one result waits in the output register and a
// second in the result stage; in_ready then drops until space frees up.
// Reset (synchronous, rst_n low) empties the table, the categories, the
// matching state and both result registers; the block is ready at once.
// ----------------------------------------------------------------------------
module url_category_substring_match #(
  parameter int GROUP_COUNT     = 8,
  parameter int SLOTS_PER_GROUP = 8,
  parameter int PATTERN_BYTES   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ucsm_pkg::FUNC_W-1:0]   in_func,
  input  logic [ucsm_pkg::GRP_W-1:0]    in_group_index,
  input  logic [ucsm_pkg::SLOT_W-1:0]   in_slot_index,
  input  logic [ucsm_pkg::POS_W-1:0]    in_char_position,
  input  logic [ucsm_pkg::BYTE_W-1:0]   in_byte_value,
  input  logic [ucsm_pkg::CAT_W-1:0]    in_group_type,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ucsm_pkg::CAT_W-1:0]    out_match_type
);
  import ucsm_pkg::*;

  localparam int PATTERN_TOTAL = GROUP_COUNT * SLOTS_PER_GROUP;

  logic                   in_fire, in_range, url_fire, feed, pend_move;
  logic                   text_ended_r, text_ended_nxt;
  logic [CAT_W-1:0]       cat_r [GROUP_COUNT];
  logic [CAT_W-1:0]       snap_cat_r [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] grp_hit, grp_hit_r;
  logic                   pend_r, out_valid_r;
  logic [CAT_W-1:0]       out_type_r, pick;
  logic [PATTERN_TOTAL-1:0] hit, nz_chain;

  // Handshakes: the result stage may refill as it drains.
  assign pend_move = pend_r && (!out_valid_r || out_ready);
  assign in_ready  = !pend_r || pend_move;
  assign in_fire   = in_valid && in_ready;
  assign url_fire  = in_fire && (in_func == FUNC_URL);
  assign in_range  = (int'(in_group_index) < GROUP_COUNT)
                  && (int'(in_slot_index) < SLOTS_PER_GROUP)
                  && (int'(in_char_position) < PATTERN_BYTES);
  assign feed      = url_fire && !text_ended_r && (in_byte_value != TEXT_END);

  // Row of pattern cells, group by group.
  for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_grp
    for (genvar s = 0; s < SLOTS_PER_GROUP; s++) begin : g_slot
      localparam int P = g * SLOTS_PER_GROUP + s;
      cell_ctrl_t ctrl;
      logic       nz_prev;
      assign ctrl.wr    = in_fire && (in_func == FUNC_WRITE) && in_range
                       && (int'(in_group_index) == g) && (int'(in_slot_index) == s);
      assign ctrl.feed  = feed;
      assign ctrl.flush = url_fire && in_last_byte;
      assign ctrl.clr   = in_fire && (in_func == FUNC_CLEAR);
      if (s == 0) begin : g_first
        assign nz_prev = 1'b1;
      end else begin : g_next
        assign nz_prev = nz_chain[P-1];
      end
      ucsm_cell #(.PATTERN_BYTES(PATTERN_BYTES)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .wr_pos    (in_char_position),
        .wr_byte   (in_byte_value),
        .text_byte (in_byte_value),
        .nz_in     (nz_prev),
        .nz_out    (nz_chain[P]),
        .hit       (hit[P])
      );
    end
    assign grp_hit[g] = |hit[g*SLOTS_PER_GROUP +: SLOTS_PER_GROUP];
  end

  // Group categories and end-of-text flag.
  always_comb begin
    text_ended_nxt = text_ended_r;
    if (in_fire && in_func == FUNC_CLEAR) begin
      text_ended_nxt = 1'b0;
    end else if (url_fire) begin
      if (in_last_byte) begin
        text_ended_nxt = 1'b0;
      end else if (in_byte_value == TEXT_END) begin
        text_ended_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_ended_r <= 1'b0;
      for (int g = 0; g < GROUP_COUNT; g++) cat_r[g] <= '0;
    end else begin
      text_ended_r <= text_ended_nxt;
      if (in_fire && in_func == FUNC_CLEAR) begin
        for (int g = 0; g < GROUP_COUNT; g++) cat_r[g] <= '0;
      end else if (in_fire && in_func == FUNC_WRITE && in_range) begin
        for (int g = 0; g < GROUP_COUNT; g++) begin
          if (int'(in_group_index) == g) cat_r[g] <= in_group_type;
        end
      end
    end
  end

  // Result stage: group hits and categories as of the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (url_fire && in_last_byte) begin
      pend_r <= 1'b1;
    end else if (pend_move) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (url_fire && in_last_byte) begin
      grp_hit_r <= grp_hit;
      for (int g = 0; g < GROUP_COUNT; g++) snap_cat_r[g] <= cat_r[g];
    end
  end

  // Priority pick: first hit group, scanning stops at a zero category.
  always_comb begin
    logic live;
    logic done;
    live = 1'b1;
    done = 1'b0;
    pick = '0;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      live = live && (snap_cat_r[g] != '0);
      if (live && !done && grp_hit_r[g]) begin
        pick = snap_cat_r[g];
        done = 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) out_type_r <= pick;
  end

  assign out_valid      = out_valid_r;
  assign out_match_type = out_type_r;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the URL category substring matcher. Pattern table
// loads, clears and URL byte streams are driven with random idling on both
// channels; a behavioural copy of the pattern table and shift-and matchers
// predicts each category, and every out_ transaction is compared with it.
// ----------------------------------------------------------------------------
module tb_top;
  import ucsm_pkg::*;

  localparam int NGRP   = 8;
  localparam int NSLOT  = 8;
  localparam int NBYTE  = 32;
  localparam int NPAT   = NGRP * NSLOT;
  localparam int LIMIT  = 400000;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = FUNC_WRITE;
  logic [GRP_W-1:0] in_group_index = '0;
  logic [SLOT_W-1:0] in_slot_index = '0;
  logic [POS_W-1:0] in_char_position = '0;
  logic [BYTE_W-1:0] in_byte_value = '0;
  logic [CAT_W-1:0] in_group_type = '0;
  logic in_last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CAT_W-1:0] out_match_type;

  // Predictor state: table, categories and per-pattern matcher.
  logic [BYTE_W-1:0] pat_mem [NPAT][NBYTE];
  logic [CAT_W-1:0] grp_cat [NGRP];
  logic [NBYTE-1:0] pm_vec [NPAT];
  logic found [NPAT];
  logic url_done;

  logic [CAT_W-1:0] expected_cats [$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int items_sent = 0;
  logic idle_enable = 1'b1;

  // Popular bytes used for random URLs and patterns so that matches occur.
  logic [BYTE_W-1:0] alphabet [4] = '{8'h61, 8'h62, 8'h63, 8'hff};

  url_category_substring_match i_dut (.*);

  always #5 clk = ~clk;

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      out_ready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk);
      if (idle_enable && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(negedge clk);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_cats.size() == 0) begin
        $error("unexpected transaction: match_type actual %0d", out_match_type);
        errors <= errors + 1;
      end else begin
        if (out_match_type !== expected_cats[0]) begin
          $error("match_type mismatch: expected %0d actual %0d",
                 expected_cats[0], out_match_type);
          errors <= errors + 1;
        end
        void'(expected_cats.pop_front());
      end
    end
  end

  function automatic void reset_matchers();
    for (int p = 0; p < NPAT; p++) begin
      pm_vec[p] = '0;
      found[p] = 1'b0;
    end
    url_done = 1'b0;
  endfunction

  function automatic void wipe_table();
    for (int p = 0; p < NPAT; p++)
      for (int k = 0; k < NBYTE; k++) pat_mem[p][k] = '0;
    for (int g = 0; g < NGRP; g++) grp_cat[g] = '0;
    reset_matchers();
  endfunction

  // Advance every pattern's shift-and vector by one text byte.
  function automatic void advance_matchers(logic [BYTE_W-1:0] b);
    int len;
    logic [NBYTE-1:0] eq, d;
    for (int p = 0; p < NPAT; p++) begin
      len = 0;
      while (len < NBYTE && pat_mem[p][len] != TEXT_END) len++;
      eq = '0;
      for (int k = 0; k < len; k++) eq[k] = (pat_mem[p][k] == b);
      d = ((pm_vec[p] << 1) | 1) & eq;
      pm_vec[p] = (len == 0) ? '0 : d;
      if (len != 0 && d[len-1]) found[p] = 1'b1;
    end
  endfunction

  function automatic logic [CAT_W-1:0] pick_first_category();
    for (int g = 0; g < NGRP && grp_cat[g] != 0; g++)
      for (int s = 0; s < NSLOT; s++) begin
        if (pat_mem[g*NSLOT+s][0] == TEXT_END) break;
        if (found[g*NSLOT+s]) return grp_cat[g];
      end
    return '0;
  endfunction

  // Predict the effect of one accepted transaction.
  function automatic void predict_category(logic [FUNC_W-1:0] f, logic [GRP_W-1:0] g,
      logic [SLOT_W-1:0] s, logic [POS_W-1:0] c, logic [BYTE_W-1:0] b,
      logic [CAT_W-1:0] t, logic last);
    case (f)
      FUNC_WRITE: begin
        pat_mem[g*NSLOT+s][c] = b;
        grp_cat[g] = t;
      end
      FUNC_CLEAR: wipe_table();
      FUNC_URL: begin
        if (!url_done) begin
          if (b == TEXT_END) url_done = 1'b1;
          else advance_matchers(b);
        end
        if (last) begin
          expected_cats.push_back(pick_first_category());
          reset_matchers();
        end
      end
      default: ;
    endcase
  endfunction

  // Send one transaction, with an optional idle burst first.
  task automatic send_item(logic [FUNC_W-1:0] f, logic [GRP_W-1:0] g,
      logic [SLOT_W-1:0] s, logic [POS_W-1:0] c, logic [BYTE_W-1:0] b,
      logic [CAT_W-1:0] t, logic last);
    int n;
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 7);
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_group_index <= g;
    in_slot_index <= s;
    in_char_position <= c;
    in_byte_value <= b;
    in_group_type <= t;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    predict_category(f, g, s, c, b, t, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_cats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_pattern(int g, int s, string txt, logic [CAT_W-1:0] cat);
    for (int k = 0; k < txt.len(); k++)
      send_item(FUNC_WRITE, GRP_W'(g), SLOT_W'(s), POS_W'(k), txt[k], cat, 1'b0);
  endtask

  task automatic send_url(string txt);
    for (int k = 0; k < txt.len(); k++)
      send_item(FUNC_URL, GRP_W'($urandom), SLOT_W'($urandom), POS_W'($urandom),
                txt[k], CAT_W'($urandom), k == txt.len() - 1);
  endtask

  // Directed: extremes, text end, spare code, clear.
  task automatic test_directed();
    send_url("ab");                              // empty table gives 0
    load_pattern(0, 0, "ab", 8'd255);
    load_pattern(1, 0, "c", 8'd1);
    send_url("xab");                             // group 0 matches
    send_item(FUNC_URL, 3'd0, 3'd0, 5'd0, 8'hff, 8'd0, 1'b0);
    send_item(FUNC_URL, 3'd0, 3'd0, 5'd0, TEXT_END, 8'd0, 1'b0);
    send_item(FUNC_URL, 3'd0, 3'd0, 5'd0, "c", 8'd0, 1'b1);  // byte after text end ignored
    send_item(FUNC_WRITE, 3'd7, 3'd7, 5'd31, 8'hff, 8'd200, 1'b1);
    send_item(FUNC_SPARE, 3'd7, 3'd7, 5'd31, 8'hff, 8'hff, 1'b1);
    send_url("c");
    send_item(FUNC_CLEAR, 3'd7, 3'd7, 5'd31, 8'hff, 8'hff, 1'b1);
    send_url("c");
  endtask

  // Load behind an empty slot, send a URL, then pause the sender until every result is back.
  task automatic test_quiet_pause();
    load_pattern(0, 1, "b", 8'd9);               // slot 0 empty: scan stops
    send_url("b");
    drain_results();
  endtask

  // Random: mostly loads of short patterns and URLs, some noise and clears.
  task automatic test_random(int count);
    int sent, len, kind;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 2) begin
        send_item(FUNC_CLEAR, GRP_W'($urandom), SLOT_W'($urandom), POS_W'($urandom),
                  BYTE_W'($urandom), CAT_W'($urandom), 1'($urandom));
        sent++;
      end else if (kind < 5) begin
        send_item(FUNC_SPARE, GRP_W'($urandom), SLOT_W'($urandom), POS_W'($urandom),
                  BYTE_W'($urandom), CAT_W'($urandom), 1'($urandom));
        sent++;
      end else if (kind < 40) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send_item(FUNC_WRITE, GRP_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 2)),
                    ($urandom_range(0, 9) == 0) ? POS_W'($urandom) : POS_W'(k),
                    ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom)
                                                : alphabet[$urandom_range(0, 3)],
                    ($urandom_range(0, 9) == 0) ? 8'd0 : CAT_W'($urandom),
                    1'($urandom));
          sent++;
        end
      end else begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          send_item(FUNC_URL, GRP_W'($urandom), SLOT_W'($urandom), POS_W'($urandom),
                    ($urandom_range(0, 19) == 0) ? TEXT_END :
                    ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom)
                                                : alphabet[$urandom_range(0, 3)],
                    CAT_W'($urandom), k == len - 1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    wipe_table();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_quiet_pause();
    test_random(1700);
    idle_enable = 1'b0;
    test_random(300);
    drain_results();
    $display("Covered %0d input transactions and %0d category results.",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ucsm_pkg.sv
design/ucsm_cell.sv
design/url_category_substring_match.sv
verif/tb_top.sv
